// ===== src/kto_pkg.sv =====
// Shared constants and types for the topological order engine.
package kto_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W = 6;
  localparam int CNT_W = 7;
  localparam int EADDR_W = 8;
  localparam int ECNT_W = 9;
  localparam int DEG_W = 9;

  localparam logic [1:0] OP_FLAG = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_SORT = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] KIND_ORDER = 2'd0;
  localparam logic [1:0] KIND_CYCLE = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  // One edge: dependent node and the node it waits for.
  typedef struct packed {
    logic [NODE_W-1:0] dep;
    logic [NODE_W-1:0] waitn;
  } edge_t;

endpackage

// ===== src/kahn_topological_order.sv =====
// Top level of the Kahn topological order engine.
//
//  channel   signals                                    handshake
//  command   start, opcode, node_a, node_b, skip_flag   start & !busy
//  config    node_count_we, node_count_wdata            node_count_we
//  result    node_index, result_kind, last              result_valid, no stall
//
// Flag, clear and stored-edge commands complete without leaving idle. An edge into a full
// store shows its result the next cycle and holds busy for that cycle.
// A sort first clears every entry of the in-degree memory, then counts the in-degree
// of each dependent over the live stored edges. It seeds the queue with the zero
// in-degree nodes in index order, then dequeues each node and walks the edge store
// to release its dependents. A final scan reports the nodes left on a cycle and
// closes the sort with the held result or the empty marker, marked last.
// Reset is synchronous; in-degrees are cleared at every sort. Results cannot be stalled.
module kahn_topological_order (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        opcode,
  input  logic [kto_pkg::NODE_W-1:0]        node_a,
  input  logic [kto_pkg::NODE_W-1:0]        node_b,
  input  logic                              skip_flag,
  input  logic                              node_count_we,
  input  logic [kto_pkg::CNT_W-1:0]         node_count_wdata,
  output logic                              result_valid,
  output logic [kto_pkg::NODE_W-1:0]        node_index,
  output logic [1:0]                        result_kind,
  output logic                              last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_EDGE_RD = 4'd2;
  localparam logic [3:0] S_EDGE_DEG = 4'd3;
  localparam logic [3:0] S_EDGE_WR = 4'd4;
  localparam logic [3:0] S_SEED_RD = 4'd5;
  localparam logic [3:0] S_SEED_CHK = 4'd6;
  localparam logic [3:0] S_POP = 4'd7;
  localparam logic [3:0] S_TAKE = 4'd8;
  localparam logic [3:0] S_SCAN_RD = 4'd9;
  localparam logic [3:0] S_SCAN_CHK = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state, state_next;
  logic [kto_pkg::CNT_W-1:0] node_count;
  logic [kto_pkg::MAX_NODES-1:0] skip, skip_next;
  logic [kto_pkg::ECNT_W-1:0] edge_count, edge_count_next;
  logic [kto_pkg::CNT_W-1:0] head, head_next;
  logic [kto_pkg::CNT_W-1:0] tail, tail_next;
  logic [kto_pkg::ECNT_W-1:0] eptr, eptr_next;
  logic [kto_pkg::CNT_W-1:0] idx, idx_next;
  logic [kto_pkg::CNT_W-1:0] emitted, emitted_next;
  logic [kto_pkg::NODE_W-1:0] cur, cur_next;
  logic walking, walking_next;
  logic pend_valid, pend_valid_next;
  logic [kto_pkg::NODE_W-1:0] pend_node, pend_node_next;
  logic [1:0] pend_kind, pend_kind_next;
  logic result_valid_next;
  logic [kto_pkg::NODE_W-1:0] node_index_next;
  logic [1:0] result_kind_next;
  logic last_next;
  logic [kto_pkg::CNT_W-1:0] n_lim;
  kto_pkg::edge_t rdata;
  logic [kto_pkg::EADDR_W-1:0] raddr;
  logic ram_we;
  logic live;
  logic accept;
  logic [kto_pkg::NODE_W-1:0] idx_n;

  // In-degree memory
  logic [kto_pkg::DEG_W-1:0] deg_mem [kto_pkg::MAX_NODES];
  logic [kto_pkg::NODE_W-1:0] deg_raddr;
  logic [kto_pkg::NODE_W-1:0] deg_waddr;
  logic [kto_pkg::DEG_W-1:0] deg_wdata;
  logic deg_we;
  logic [kto_pkg::DEG_W-1:0] deg_q;

  // Ready queue memory
  logic [kto_pkg::NODE_W-1:0] fifo_mem [kto_pkg::MAX_NODES];
  logic [kto_pkg::NODE_W-1:0] fifo_raddr;
  logic [kto_pkg::NODE_W-1:0] fifo_waddr;
  logic [kto_pkg::NODE_W-1:0] fifo_wdata;
  logic fifo_we;
  logic [kto_pkg::NODE_W-1:0] fifo_q;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign n_lim = (node_count > kto_pkg::CNT_W'(kto_pkg::MAX_NODES)) ?
                 kto_pkg::CNT_W'(kto_pkg::MAX_NODES) : node_count;
  assign ram_we = accept && opcode == kto_pkg::OP_EDGE &&
                  edge_count < kto_pkg::ECNT_W'(kto_pkg::MAX_EDGES);
  assign raddr = eptr[kto_pkg::EADDR_W-1:0];
  assign idx_n = idx[kto_pkg::NODE_W-1:0];
  assign deg_raddr = (state == S_EDGE_DEG) ? rdata.dep : idx_n;
  assign fifo_raddr = head[kto_pkg::NODE_W-1:0];
  assign fifo_waddr = tail[kto_pkg::NODE_W-1:0];

  // Edge liveness of the word just read.
  assign live = {1'b0, rdata.dep} < n_lim && {1'b0, rdata.waitn} < n_lim &&
                !skip[rdata.dep] && !skip[rdata.waitn];

  kto_edge_ram u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(edge_count[kto_pkg::EADDR_W-1:0]),
    .wdata({node_a, node_b}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Write and read the in-degree memory.
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_q <= deg_mem[deg_raddr];
  end

  // Write and read the ready queue.
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    fifo_q <= fifo_mem[fifo_raddr];
  end

  // Hold the node count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (node_count_we) begin
      node_count <= node_count_wdata;
    end
  end

  // Sequence commands and the sort; each result is held back one step so
  // the final one of a sort can carry last.
  always_comb begin
    state_next = state;
    skip_next = skip;
    edge_count_next = edge_count;
    head_next = head;
    tail_next = tail;
    eptr_next = eptr;
    idx_next = idx;
    emitted_next = emitted;
    cur_next = cur;
    walking_next = walking;
    pend_valid_next = pend_valid;
    pend_node_next = pend_node;
    pend_kind_next = pend_kind;
    result_valid_next = 1'b0;
    node_index_next = node_index;
    result_kind_next = result_kind;
    last_next = last;
    deg_we = 1'b0;
    deg_waddr = idx_n;
    deg_wdata = '0;
    fifo_we = 1'b0;
    fifo_wdata = rdata.dep;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            kto_pkg::OP_FLAG: skip_next[node_a] = skip_flag;
            kto_pkg::OP_EDGE: begin
              if (ram_we) begin
                edge_count_next = edge_count + 1'b1;
              end else begin
                state_next = S_DONE;
                result_valid_next = 1'b1;
                node_index_next = '0;
                result_kind_next = kto_pkg::KIND_FULL;
                last_next = 1'b1;
              end
            end
            kto_pkg::OP_SORT: begin
              idx_next = '0;
              head_next = '0;
              tail_next = '0;
              emitted_next = '0;
              pend_valid_next = 1'b0;
              state_next = S_CLEAR;
            end
            kto_pkg::OP_CLEAR: begin
              edge_count_next = '0;
              skip_next = '0;
            end
            default: ;
          endcase
        end
      end
      // Zero one in-degree entry per cycle.
      S_CLEAR: begin
        deg_we = 1'b1;
        if (idx == kto_pkg::CNT_W'(kto_pkg::MAX_NODES - 1)) begin
          idx_next = '0;
          eptr_next = '0;
          walking_next = 1'b0;
          state_next = S_EDGE_RD;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      // Read the next edge, or close the pass over the store.
      S_EDGE_RD: begin
        if (eptr < edge_count) begin
          state_next = S_EDGE_DEG;
        end else if (walking) begin
          state_next = S_POP;
        end else begin
          idx_next = '0;
          state_next = S_SEED_RD;
        end
      end
      // Fetch the in-degree of the dependent when the edge applies.
      S_EDGE_DEG: begin
        if (live && (!walking || rdata.waitn == cur)) begin
          state_next = S_EDGE_WR;
        end else begin
          eptr_next = eptr + 1'b1;
          state_next = S_EDGE_RD;
        end
      end
      // Count the edge, or release the dependent and queue it at zero.
      S_EDGE_WR: begin
        deg_waddr = rdata.dep;
        if (!walking) begin
          deg_we = 1'b1;
          deg_wdata = deg_q + 1'b1;
        end else if (deg_q != '0) begin
          deg_we = 1'b1;
          deg_wdata = deg_q - 1'b1;
          if (deg_q == kto_pkg::DEG_W'(1) &&
              tail < kto_pkg::CNT_W'(kto_pkg::MAX_NODES)) begin
            fifo_we = 1'b1;
            tail_next = tail + 1'b1;
          end
        end
        eptr_next = eptr + 1'b1;
        state_next = S_EDGE_RD;
      end
      // Queue zero in-degree nodes in index order.
      S_SEED_RD: begin
        if (idx < n_lim) begin
          state_next = S_SEED_CHK;
        end else begin
          state_next = S_POP;
        end
      end
      S_SEED_CHK: begin
        if (!skip[idx_n] && deg_q == '0) begin
          fifo_we = 1'b1;
          fifo_wdata = idx_n;
          tail_next = tail + 1'b1;
        end
        idx_next = idx + 1'b1;
        state_next = S_SEED_RD;
      end
      // Dequeue the next node, or move on to the cycle scan.
      S_POP: begin
        if (head < tail) begin
          state_next = S_TAKE;
        end else begin
          idx_next = '0;
          state_next = S_SCAN_RD;
        end
      end
      // Report the dequeued node and walk the store for its dependents.
      S_TAKE: begin
        if (pend_valid) begin
          result_valid_next = 1'b1;
          node_index_next = pend_node;
          result_kind_next = pend_kind;
          last_next = 1'b0;
        end
        pend_valid_next = 1'b1;
        pend_node_next = fifo_q;
        pend_kind_next = kto_pkg::KIND_ORDER;
        emitted_next = emitted + 1'b1;
        cur_next = fifo_q;
        head_next = head + 1'b1;
        eptr_next = '0;
        walking_next = 1'b1;
        state_next = S_EDGE_RD;
      end
      // Report nodes left on a cycle.
      S_SCAN_RD: begin
        if (idx < n_lim) begin
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN_CHK: begin
        if (!skip[idx_n] && deg_q != '0 &&
            emitted < kto_pkg::CNT_W'(kto_pkg::MAX_NODES)) begin
          if (pend_valid) begin
            result_valid_next = 1'b1;
            node_index_next = pend_node;
            result_kind_next = pend_kind;
            last_next = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_node_next = idx_n;
          pend_kind_next = kto_pkg::KIND_CYCLE;
          emitted_next = emitted + 1'b1;
        end
        idx_next = idx + 1'b1;
        state_next = S_SCAN_RD;
      end
      // Close the command with the held result or the empty marker.
      S_FINISH: begin
        result_valid_next = 1'b1;
        last_next = 1'b1;
        if (pend_valid) begin
          node_index_next = pend_node;
          result_kind_next = pend_kind;
        end else begin
          node_index_next = '0;
          result_kind_next = kto_pkg::KIND_NONE;
        end
        pend_valid_next = 1'b0;
        state_next = S_IDLE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      skip <= '0;
      edge_count <= '0;
      head <= '0;
      tail <= '0;
      eptr <= '0;
      idx <= '0;
      emitted <= '0;
      cur <= '0;
      walking <= 1'b0;
      pend_valid <= 1'b0;
      pend_node <= '0;
      pend_kind <= kto_pkg::KIND_ORDER;
      result_valid <= 1'b0;
      node_index <= '0;
      result_kind <= kto_pkg::KIND_ORDER;
      last <= 1'b0;
    end else begin
      state <= state_next;
      skip <= skip_next;
      edge_count <= edge_count_next;
      head <= head_next;
      tail <= tail_next;
      eptr <= eptr_next;
      idx <= idx_next;
      emitted <= emitted_next;
      cur <= cur_next;
      walking <= walking_next;
      pend_valid <= pend_valid_next;
      pend_node <= pend_node_next;
      pend_kind <= pend_kind_next;
      result_valid <= result_valid_next;
      node_index <= node_index_next;
      result_kind <= result_kind_next;
      last <= last_next;
    end
  end

endmodule

// ===== src/kto_edge_ram.sv =====
// Edge store: one write port, one registered read port.
module kto_edge_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [kto_pkg::EADDR_W-1:0] waddr,
  input  kto_pkg::edge_t              wdata,
  input  logic [kto_pkg::EADDR_W-1:0] raddr,
  output kto_pkg::edge_t              rdata
);

  kto_pkg::edge_t mem [kto_pkg::MAX_EDGES];

  // Write and read the edge array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kahn_topological_order_check.sv =====
// Port-level checker for the topological order engine, with its bind.
module kahn_topological_order_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       result_valid,
  input logic [1:0] result_kind,
  input logic       last
);

  a_full_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == kto_pkg::KIND_FULL |-> last)
    else $error("full result without last");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == kto_pkg::KIND_NONE |-> last)
    else $error("empty marker without last");

  a_flag_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == kto_pkg::OP_FLAG |=> !busy && !result_valid)
    else $error("flag command produced output");

  a_sort_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == kto_pkg::OP_SORT |=> busy)
    else $error("sort did not start");

endmodule

bind kahn_topological_order kahn_topological_order_check u_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
  .result_valid(result_valid), .result_kind(result_kind), .last(last)
);

// ===== sim/kahn_topological_order_test.sv =====
// Self-checking testbench for the Kahn topological order engine.
module kahn_topological_order_test;

  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [kto_pkg::NODE_W-1:0] node;
    logic [1:0]                 kind;
    logic                       last;
  } order_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 opcode = kto_pkg::OP_FLAG;
  logic [kto_pkg::NODE_W-1:0] node_a = '0;
  logic [kto_pkg::NODE_W-1:0] node_b = '0;
  logic                       skip_flag = 1'b0;
  logic                       node_count_we = 1'b0;
  logic [kto_pkg::CNT_W-1:0]  node_count_wdata = '0;
  logic                       result_valid;
  logic [kto_pkg::NODE_W-1:0] node_index;
  logic [1:0]                 result_kind;
  logic                       last;

  // Shadow copy of the graph state
  logic                       skip_tbl [kto_pkg::MAX_NODES];
  logic [kto_pkg::NODE_W-1:0] arc_dep [kto_pkg::MAX_EDGES];
  logic [kto_pkg::NODE_W-1:0] arc_wait [kto_pkg::MAX_EDGES];
  int                         arc_cnt;
  int                         nodes_used;

  order_item_t       order_q [$];
  int                err_cnt = 0;
  int                item_cnt = 0;
  int                result_cnt = 0;
  int                sort_cnt = 0;
  int                gap_pct = 0;
  int                quiet_cycles = 0;

  kahn_topological_order u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .node_a(node_a), .node_b(node_b), .skip_flag(skip_flag),
    .node_count_we(node_count_we), .node_count_wdata(node_count_wdata),
    .result_valid(result_valid), .node_index(node_index),
    .result_kind(result_kind), .last(last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic bit arc_live(input int e, input int n);
    int a;
    int b;
    a = arc_dep[e];
    b = arc_wait[e];
    if (a >= n || b >= n) return 1'b0;
    return !skip_tbl[a] && !skip_tbl[b];
  endfunction

  function automatic void push_order(input int node, input logic [1:0] kind);
    order_item_t it;
    it.node = node[kto_pkg::NODE_W-1:0];
    it.kind = kind;
    it.last = 1'b0;
    order_q = {order_q, it};
  endfunction

  // Expected topological order, then nodes still on a cycle
  function automatic void predict_order();
    int n;
    int head;
    int tail;
    int k;
    int u;
    int v;
    int indeg [kto_pkg::MAX_NODES];
    int ready [kto_pkg::MAX_NODES];
    n = (nodes_used > kto_pkg::MAX_NODES) ? kto_pkg::MAX_NODES : nodes_used;
    head = 0;
    tail = 0;
    k = 0;
    for (int i = 0; i < kto_pkg::MAX_NODES; i++) indeg[i] = 0;
    for (int e = 0; e < arc_cnt; e++)
      if (arc_live(e, n)) indeg[arc_dep[e]]++;
    for (int i = 0; i < n; i++)
      if (!skip_tbl[i] && indeg[i] == 0) ready[tail++] = i;
    while (head < tail) begin
      u = ready[head++];
      push_order(u, kto_pkg::KIND_ORDER);
      k++;
      for (int e = 0; e < arc_cnt; e++) begin
        if (arc_wait[e] != u || !arc_live(e, n)) continue;
        v = arc_dep[e];
        if (indeg[v] > 0) begin
          indeg[v]--;
          if (indeg[v] == 0 && tail < kto_pkg::MAX_NODES) ready[tail++] = v;
        end
      end
    end
    for (int i = 0; i < n; i++)
      if (!skip_tbl[i] && indeg[i] > 0 && k < kto_pkg::MAX_NODES) begin
        push_order(i, kto_pkg::KIND_CYCLE);
        k++;
      end
    if (k == 0) push_order(0, kto_pkg::KIND_NONE);
    order_q[order_q.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_cmd(input logic [1:0] op,
                                      input logic [kto_pkg::NODE_W-1:0] a,
                                      input logic [kto_pkg::NODE_W-1:0] b,
                                      input logic f);
    case (op)
      kto_pkg::OP_FLAG: skip_tbl[a] = f;
      kto_pkg::OP_EDGE: begin
        if (arc_cnt >= kto_pkg::MAX_EDGES) begin
          push_order(0, kto_pkg::KIND_FULL);
          order_q[order_q.size()-1].last = 1'b1;
        end else begin
          arc_dep[arc_cnt] = a;
          arc_wait[arc_cnt] = b;
          arc_cnt++;
        end
      end
      kto_pkg::OP_SORT: begin
        predict_order();
        sort_cnt++;
      end
      default: begin
        arc_cnt = 0;
        for (int i = 0; i < kto_pkg::MAX_NODES; i++) skip_tbl[i] = 1'b0;
      end
    endcase
  endfunction

  // Drive one command and hold it until the block takes it
  task automatic send_cmd(input logic [1:0] op, input int a, input int b, input logic f);
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    node_a <= a[kto_pkg::NODE_W-1:0];
    node_b <= b[kto_pkg::NODE_W-1:0];
    skip_flag <= f;
    do @(posedge clk); while (busy);
    predict_cmd(op, a[kto_pkg::NODE_W-1:0], b[kto_pkg::NODE_W-1:0], f);
    item_cnt++;
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // Drop start and wait for every expected result plus a few settle cycles
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    drain();
    @(negedge clk);
    node_count_we <= 1'b1;
    node_count_wdata <= value[kto_pkg::CNT_W-1:0];
    @(negedge clk);
    node_count_we <= 1'b0;
    nodes_used = value;
  endtask

  task automatic test_directed();
    write_node_count(0);
    send_cmd(kto_pkg::OP_SORT, 0, 0, 1'b0);
    write_node_count(1);
    send_cmd(kto_pkg::OP_SORT, 63, 63, 1'b1);
    write_node_count(64);
    send_cmd(kto_pkg::OP_EDGE, 1, 0, 1'b0);
    send_cmd(kto_pkg::OP_EDGE, 2, 1, 1'b0);
    send_cmd(kto_pkg::OP_EDGE, 63, 2, 1'b0);
    send_cmd(kto_pkg::OP_EDGE, 5, 5, 1'b0);
    send_cmd(kto_pkg::OP_EDGE, 7, 8, 1'b0);
    send_cmd(kto_pkg::OP_EDGE, 8, 7, 1'b0);
    send_cmd(kto_pkg::OP_FLAG, 63, 0, 1'b1);
    send_cmd(kto_pkg::OP_FLAG, 0, 0, 1'b1);
    send_cmd(kto_pkg::OP_FLAG, 0, 0, 1'b0);
    send_cmd(kto_pkg::OP_SORT, 0, 0, 1'b0);
    // node count above the node limit behaves as the limit
    write_node_count(127);
    send_cmd(kto_pkg::OP_SORT, 0, 0, 1'b0);
    // edges past the node count are ignored
    write_node_count(5);
    send_cmd(kto_pkg::OP_EDGE, 3, 40, 1'b0);
    send_cmd(kto_pkg::OP_EDGE, 4, 3, 1'b0);
    send_cmd(kto_pkg::OP_SORT, 0, 0, 1'b0);
    send_cmd(kto_pkg::OP_CLEAR, 0, 0, 1'b0);
    send_cmd(kto_pkg::OP_SORT, 0, 0, 1'b0);
  endtask

  task automatic test_random_graphs();
    int pcts [3] = '{0, 51, 30};
    int n;
    int a;
    int b;
    foreach (pcts[p]) begin
      gap_pct = pcts[p];
      for (int r = 0; r < 5; r++) begin
        n = ($urandom_range(9) < 8) ? $urandom_range(2, 12)
                                    : ($urandom_range(1) ? 64 : $urandom_range(127));
        write_node_count(n);
        send_cmd(kto_pkg::OP_CLEAR, 0, 0, 1'b0);
        repeat ($urandom_range(0, 2))
          send_cmd(kto_pkg::OP_FLAG, $urandom_range(63), $urandom_range(63),
                   1'($urandom_range(1)));
        repeat ($urandom_range(4, 9)) begin
          // mostly forward edges; some backward, self or arbitrary ones
          a = $urandom_range(((n > 64 ? 64 : n) > 0) ? ((n > 64 ? 64 : n) - 1) : 0);
          b = (a > 0) ? $urandom_range(a - 1) : 0;
          case ($urandom_range(9))
            0: send_cmd(kto_pkg::OP_EDGE, b, a, 1'b0);
            1: send_cmd(kto_pkg::OP_EDGE, $urandom_range(63), $urandom_range(63), 1'b1);
            default: send_cmd(kto_pkg::OP_EDGE, a, b, 1'($urandom_range(1)));
          endcase
        end
        send_cmd(kto_pkg::OP_SORT, $urandom_range(63), $urandom_range(63),
                 1'($urandom_range(1)));
      end
    end
    gap_pct = 0;
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    order_item_t ex;
    if (!rst && result_valid) begin
      result_cnt++;
      if (order_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result node %0d kind %0d",
                                  node_index, result_kind));
      end else begin
        ex = order_q.pop_front();
        if (node_index !== ex.node)
          report_mismatch($sformatf("node_index %0d, expected %0d", node_index, ex.node));
        if (result_kind !== ex.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", result_kind, ex.kind));
        if (last !== ex.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, ex.last));
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || node_count_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: %0d results still expected", order_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < kto_pkg::MAX_NODES; i++) skip_tbl[i] = 1'b0;
    arc_cnt = 0;
    nodes_used = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_graphs();
    drain();
    repeat (20) @(posedge clk);
    if (order_q.size() != 0) report_mismatch("expected results never arrived");
    $display("Ran %0d commands with %0d sorts, checked %0d results", item_cnt, sort_cnt,
             result_cnt);
    $display("Covered empty, cyclic, skipped and out-of-range graphs");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== kahn_topological_order.f =====
src/kto_pkg.sv
src/kto_edge_ram.sv
src/kahn_topological_order.sv
src/kahn_topological_order_check.sv
sim/kahn_topological_order_test.sv
